>>> design/luwkr_pkg.sv
`default_nettype none

package luwkr_pkg;

   localparam int MAX_WINDOW_DEF = 1024;
   localparam int ALPHABET_DEF   = 256;
   localparam int SYM_W          = 8;
   localparam int BUDGET_W       = 11;
   localparam int BEST_W         = 11;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_CNT,
      ST_PUSH_DEC,
      ST_PUSH_INC,
      ST_CHECK,
      ST_EMIT,
      ST_FLUSH,
      ST_POP_RD,
      ST_POP_SYM,
      ST_POP_CNT,
      ST_POP_HIST,
      ST_POP_INC
   } state_type;

   // Where the sequencer goes once a byte has left the window.
   typedef enum logic [1:0] {
      PH_OVF,
      PH_TRIM,
      PH_FLUSH
   } phase_type;

   typedef struct packed {
      logic req_fire;
      logic rsp_busy;
      logic win_full;
      logic trim;
      logic last;
      logic cnt_zero;
      logic old_one;
      logic len_zero;
      logic clr_done;
   } stat_type;

   typedef struct packed {
      state_type st;
      logic      req_ready;
      logic      rsp_load;
   } ctl_type;

endpackage

`default_nettype wire

>>> design/longest_uniform_window_k_replace_core.sv
`default_nettype none

// Reports, after every request byte, the longest substring of the current string that at
// most csr_replace_budget substitutions make a single repeated symbol. Per-symbol counts
// and a histogram of those counts live in synchronous RAMs with one write and one read
// port, so every byte runs a chain of read-modify-write states: PUSH_CNT, PUSH_DEC (if
// its symbol is already in the window), PUSH_INC, CHECK and EMIT. Each byte dropped from
// the left of the window adds POP_RD, POP_SYM, POP_CNT, POP_HIST and, unless its count
// falls to zero, POP_INC; a byte that finds the window full first drops one that way.
// After a byte flagged last, the block drains the remaining window before it takes the
// next request. After reset, a clearing pass over both count RAMs runs with req_ready
// low. The budget register can be written at any time and applies from the next window
// check on; a result waiting in the output register does not block the next request.
module longest_uniform_window_k_replace_core
   import luwkr_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int ALPHABET   = ALPHABET_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SYM_W-1:0]    req_sym,
   input  logic                req_last_sym,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BEST_W-1:0]   rsp_best_len,
   output logic                rsp_end_of_string,
   output logic                rsp_overflow,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [BUDGET_W-1:0] csr_replace_budget
);

   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int PW    = $clog2(MAX_WINDOW);
   localparam int SW    = $clog2(ALPHABET);
   localparam int HW    = $clog2(ALPHABET + 1);
   localparam int KLAST = (ALPHABET - 1 > MAX_WINDOW) ? ALPHABET - 1 : MAX_WINDOW;
   localparam int KW    = $clog2(KLAST + 1);
   localparam int DW    = (CW > BUDGET_W) ? CW : BUDGET_W;

   stat_type stat;
   ctl_type  ctl;

   logic [SW-1:0] sym_lut [2**SYM_W];

   for (genvar i = 0; i < 2**SYM_W; i++) begin : g_lut
      assign sym_lut[i] = SW'(i % ALPHABET);
   end

   logic [KW-1:0]       clr_ff, clr_in;
   logic [PW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]       len_ff, len_in, largest_ff, largest_in, best_ff, best_in;
   logic [CW-1:0]       old_ff, old_in;
   logic [SW-1:0]       sym_ff, sym_in, pop_sym_ff, pop_sym_in;
   logic                last_ff, last_in, ovf_ff, ovf_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BEST_W-1:0]   rsp_best_len_ff, rsp_best_len_in;
   logic                rsp_eos_ff, rsp_eos_in, rsp_ovf_ff, rsp_ovf_in;

   logic          scnt_we;
   logic [SW-1:0] scnt_waddr, scnt_raddr;
   logic [CW-1:0] scnt_wdata, scnt_rdata;
   logic          hist_we;
   logic [CW-1:0] hist_waddr, hist_raddr;
   logic [HW-1:0] hist_wdata, hist_rdata;
   logic          buf_we;
   logic [PW-1:0] buf_waddr, buf_raddr;
   logic [SW-1:0] buf_wdata, buf_rdata;

   logic          req_fire, push_now;
   logic [SW-1:0] push_sym;
   logic [CW-1:0] old_inc, old_dec;

   luwkr_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_scnt (
      .clock   (clock),
      .wr_en   (scnt_we),
      .wr_addr (scnt_waddr),
      .wr_data (scnt_wdata),
      .rd_addr (scnt_raddr),
      .rd_data (scnt_rdata)
   );

   luwkr_ram #(.WIDTH(HW), .DEPTH(MAX_WINDOW + 1)) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   luwkr_ram #(.WIDTH(SW), .DEPTH(MAX_WINDOW)) u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   luwkr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   assign req_ready = ctl.req_ready;
   assign req_fire  = req_valid && ctl.req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      stat.req_fire = req_fire;
      stat.rsp_busy = rsp_valid_ff && !rsp_ready;
      stat.win_full = (len_ff == CW'(MAX_WINDOW));
      stat.trim     = (len_ff > largest_ff) &&
                      (DW'(len_ff - largest_ff) > DW'(budget_ff));
      stat.last     = last_ff;
      stat.cnt_zero = (scnt_rdata == '0);
      stat.old_one  = (old_ff == CW'(1));
      stat.len_zero = (len_ff == '0);
      stat.clr_done = (clr_ff == KW'(KLAST));
   end

   // A byte goes straight into the window on acceptance unless the window is full;
   // then the oldest byte leaves first and the push runs from its own state.
   assign push_now = (ctl.st == ST_IDLE && req_fire && !stat.win_full) ||
                     (ctl.st == ST_PUSH_RD);
   assign push_sym = (ctl.st == ST_IDLE) ? sym_lut[req_sym] : sym_ff;
   assign old_inc  = old_ff + CW'(1);
   assign old_dec  = old_ff - CW'(1);

   always_comb begin
      clr_in     = clr_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      len_in     = len_ff;
      largest_in = largest_ff;
      best_in    = best_ff;
      old_in     = old_ff;
      sym_in     = sym_ff;
      pop_sym_in = pop_sym_ff;
      last_in    = last_ff;
      ovf_in     = ovf_ff;

      scnt_we    = 1'b0;
      scnt_waddr = sym_ff;
      scnt_wdata = scnt_rdata + CW'(1);
      scnt_raddr = push_sym;
      hist_we    = 1'b0;
      hist_waddr = old_ff;
      hist_wdata = hist_rdata + HW'(1);
      hist_raddr = old_ff;
      buf_we     = push_now;
      buf_waddr  = head_ff;
      buf_wdata  = push_sym;
      buf_raddr  = tail_ff;

      if (push_now) begin
         head_in = (head_ff == PW'(MAX_WINDOW - 1)) ? '0 : head_ff + PW'(1);
         len_in  = len_ff + CW'(1);
      end

      case (ctl.st)
         ST_CLEAR: begin
            clr_in     = clr_ff + KW'(1);
            hist_we    = (clr_ff <= KW'(MAX_WINDOW));
            hist_waddr = CW'(clr_ff);
            hist_wdata = '0;
            scnt_we    = (clr_ff <= KW'(ALPHABET - 1));
            scnt_waddr = SW'(clr_ff);
            scnt_wdata = '0;
         end
         ST_IDLE: begin
            if (req_fire) begin
               sym_in  = sym_lut[req_sym];
               last_in = req_last_sym;
               ovf_in  = stat.win_full;
            end
         end
         ST_PUSH_CNT: begin
            old_in     = scnt_rdata;
            scnt_we    = 1'b1;
            hist_raddr = stat.cnt_zero ? CW'(1) : scnt_rdata;
         end
         ST_PUSH_DEC: begin
            hist_we    = 1'b1;
            hist_wdata = hist_rdata - HW'(1);
            hist_raddr = old_inc;
         end
         ST_PUSH_INC: begin
            hist_we    = 1'b1;
            hist_waddr = old_inc;
            if (old_inc > largest_ff) largest_in = old_inc;
         end
         ST_CHECK: begin
            if (!stat.trim && len_ff > best_ff) best_in = len_ff;
         end
         ST_EMIT: begin
            if (ctl.rsp_load && last_ff) best_in = '0;
         end
         ST_FLUSH: begin
            if (stat.len_zero) begin
               head_in = '0;
               tail_in = '0;
            end
         end
         ST_POP_RD: begin
            tail_in = (tail_ff == PW'(MAX_WINDOW - 1)) ? '0 : tail_ff + PW'(1);
            len_in  = len_ff - CW'(1);
         end
         ST_POP_SYM: begin
            pop_sym_in = buf_rdata;
            scnt_raddr = buf_rdata;
         end
         ST_POP_CNT: begin
            old_in     = scnt_rdata;
            scnt_we    = 1'b1;
            scnt_waddr = pop_sym_ff;
            scnt_wdata = scnt_rdata - CW'(1);
            hist_raddr = scnt_rdata;
         end
         ST_POP_HIST: begin
            hist_we    = 1'b1;
            hist_wdata = hist_rdata - HW'(1);
            hist_raddr = old_dec;
            // The largest count falls by one when its last holder just lost a byte.
            if (old_ff == largest_ff && hist_rdata == HW'(1)) largest_in = old_dec;
         end
         ST_POP_INC: begin
            hist_we    = 1'b1;
            hist_waddr = old_dec;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      budget_in       = csr_valid ? csr_replace_budget : budget_ff;
      rsp_valid_in    = ctl.rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_best_len_in = rsp_best_len_ff;
      rsp_eos_in      = rsp_eos_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      if (ctl.rsp_load) begin
         rsp_best_len_in = BEST_W'(best_ff);
         rsp_eos_in      = last_ff;
         rsp_ovf_in      = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         largest_ff   <= '0;
         best_ff      <= '0;
         budget_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         largest_ff   <= largest_in;
         best_ff      <= best_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff          <= old_in;
      sym_ff          <= sym_in;
      pop_sym_ff      <= pop_sym_in;
      last_ff         <= last_in;
      ovf_ff          <= ovf_in;
      rsp_best_len_ff <= rsp_best_len_in;
      rsp_eos_ff      <= rsp_eos_in;
      rsp_ovf_ff      <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_len      = rsp_best_len_ff;
   assign rsp_end_of_string = rsp_eos_ff;
   assign rsp_overflow      = rsp_ovf_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CW'(MAX_WINDOW))
      else $error("window length beyond buffer depth");

   a_largest_in_window: assert property (@(posedge clock) disable iff (reset)
      (ctl.st == ST_CHECK) |-> (largest_ff <= len_ff && largest_ff != '0))
      else $error("largest count inconsistent with window length");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ctl.st == ST_POP_RD) |-> (len_ff != '0))
      else $error("pop from an empty window");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      (ctl.st == ST_FLUSH && len_ff == '0) |-> (largest_ff == '0))
      else $error("largest count not zero after draining the window");

endmodule

`default_nettype wire

>>> design/luwkr_ram.sv
`default_nettype none

module luwkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/luwkr_seq.sv
`default_nettype none

module luwkr_seq
   import luwkr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   state_type ret_st;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= PH_TRIM;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_OVF:   ret_st = ST_PUSH_RD;
         PH_TRIM:  ret_st = ST_CHECK;
         PH_FLUSH: ret_st = ST_FLUSH;
         default:  ret_st = ST_CHECK;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (stat.req_fire) begin
               if (stat.win_full) begin
                  state_in = ST_POP_RD;
                  phase_in = PH_OVF;
               end else begin
                  state_in = ST_PUSH_CNT;
               end
            end
         end
         ST_PUSH_RD:  state_in = ST_PUSH_CNT;
         ST_PUSH_CNT: state_in = stat.cnt_zero ? ST_PUSH_INC : ST_PUSH_DEC;
         ST_PUSH_DEC: state_in = ST_PUSH_INC;
         ST_PUSH_INC: state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.trim) begin
               state_in = ST_POP_RD;
               phase_in = PH_TRIM;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!stat.rsp_busy) state_in = stat.last ? ST_FLUSH : ST_IDLE;
         end
         ST_FLUSH: begin
            if (stat.len_zero) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_POP_RD;
               phase_in = PH_FLUSH;
            end
         end
         ST_POP_RD:   state_in = ST_POP_SYM;
         ST_POP_SYM:  state_in = ST_POP_CNT;
         ST_POP_CNT:  state_in = ST_POP_HIST;
         ST_POP_HIST: state_in = stat.old_one ? ret_st : ST_POP_INC;
         ST_POP_INC:  state_in = ret_st;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctl.st        = state_ff;
      ctl.req_ready = (state_ff == ST_IDLE);
      ctl.rsp_load  = (state_ff == ST_EMIT) && !stat.rsp_busy;
   end

endmodule

`default_nettype wire
